### rtl/core/refcounted_buffer_pool_defines.svh
// Assertion macros shared by the buffer pool RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`define REFCOUNTED_BUFFER_POOL_DEFINES_SVH

// Checked outside reset only.
`define RCBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define RCBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/rcbp_pkg.sv
// Types and constants for the reference-counted buffer pool.
// No dependencies; imported by every module of the block.
package rcbp_pkg;

  localparam int unsigned MAX_BUFFERS_DEF    = 32;
  localparam int unsigned REF_COUNT_BITS_DEF = 8;

  // Fixed field widths of the request and response transfers
  localparam int unsigned ID_W      = 5;
  localparam int unsigned REF_OUT_W = 8;
  localparam int unsigned TOT_W     = 6;

  typedef enum logic [1:0] {
    REQ_ALLOC,
    REQ_ADD_REF,
    REQ_RELEASE,
    REQ_NOP
  } req_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_OUT_OF_BUFS,
    ST_ALREADY_REL,
    ST_NOT_CREATED,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    req_e            req_type;
    logic [ID_W-1:0] target_id;
  } pool_req_t;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      granted_id;
    logic [REF_OUT_W-1:0] ref_count;
    logic [TOT_W-1:0]     free_count;
    logic [TOT_W-1:0]     created_count;
  } pool_rsp_t;

endpackage

### rtl/core/rcbp_store.sv
// Reference count memory and free stack memory of the buffer pool.
// Synchronous reads with write-to-read forwarding; uses rcbp_pkg.
module rcbp_store #(
  parameter int unsigned MAX_BUFFERS    = rcbp_pkg::MAX_BUFFERS_DEF,
  parameter int unsigned REF_COUNT_BITS = rcbp_pkg::REF_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      ref_raddr_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      stk_raddr_i,
  input  logic                                ref_we_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      ref_waddr_i,
  input  logic [REF_COUNT_BITS-1:0]           ref_wdata_i,
  input  logic                                stk_we_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      stk_waddr_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      stk_wdata_i,
  output logic [REF_COUNT_BITS-1:0]           ref_rdata_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      stk_rdata_o
);
  import rcbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BUFFERS);

  logic [REF_COUNT_BITS-1:0] ref_mem [MAX_BUFFERS];
  logic [IDX_W-1:0]          stk_mem [MAX_BUFFERS];
  logic [REF_COUNT_BITS-1:0] ref_rdata_q;
  logic [IDX_W-1:0]          stk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ref_we_i) begin
      ref_mem[ref_waddr_i] <= ref_wdata_i;
    end
    // read sees the write of the same edge
    if (rd_en_i) begin
      if (ref_we_i && (ref_waddr_i == ref_raddr_i)) begin
        ref_rdata_q <= ref_wdata_i;
      end else begin
        ref_rdata_q <= ref_mem[ref_raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we_i) begin
      stk_mem[stk_waddr_i] <= stk_wdata_i;
    end
    if (rd_en_i) begin
      if (stk_we_i && (stk_waddr_i == stk_raddr_i)) begin
        stk_rdata_q <= stk_wdata_i;
      end else begin
        stk_rdata_q <= stk_mem[stk_raddr_i];
      end
    end
  end

  assign ref_rdata_o = ref_rdata_q;
  assign stk_rdata_o = stk_rdata_q;

endmodule

### rtl/core/rcbp_core.sv
// Request register, pool counters and per-request decision logic.
// Drives the memory ports of rcbp_store; uses rcbp_pkg and the assertion macros.
`include "refcounted_buffer_pool_defines.svh"

module rcbp_core #(
  parameter int unsigned MAX_BUFFERS    = rcbp_pkg::MAX_BUFFERS_DEF,
  parameter int unsigned REF_COUNT_BITS = rcbp_pkg::REF_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  rcbp_pkg::pool_req_t                 req_i,
  input  logic                                commit_i,
  input  logic [REF_COUNT_BITS-1:0]           ref_rdata_i,
  input  logic [$clog2(MAX_BUFFERS)-1:0]      stk_rdata_i,
  output logic                                s1_valid_o,
  output rcbp_pkg::pool_rsp_t                 rsp_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      ref_raddr_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      stk_raddr_o,
  output logic                                ref_we_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      ref_waddr_o,
  output logic [REF_COUNT_BITS-1:0]           ref_wdata_o,
  output logic                                stk_we_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      stk_waddr_o,
  output logic [$clog2(MAX_BUFFERS)-1:0]      stk_wdata_o
);
  import rcbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BUFFERS);
  localparam int unsigned CNT_W = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  localparam logic [REF_COUNT_BITS-1:0] CountMax = {REF_COUNT_BITS{1'b1}};
  localparam logic [REF_COUNT_BITS-1:0] CountOne = REF_COUNT_BITS'(1);
  localparam logic [CNT_W-1:0]          PoolSize = CNT_W'(MAX_BUFFERS);

  logic             s1_valid_q;
  pool_req_t        s1_req_q;
  logic [CNT_W-1:0] depth_q, depth_d, depth_eff;
  logic [CNT_W-1:0] created_q, created_d;

  logic                      not_created;
  logic [IDX_W-1:0]          id_idx;
  logic [IDX_W-1:0]          grant;
  logic [REF_COUNT_BITS-1:0] cnt, cnt_out, cnt_dec;
  status_e                   status;
  logic                      ref_we, stk_we;
  logic [IDX_W-1:0]          ref_waddr;
  logic [REF_COUNT_BITS-1:0] ref_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      depth_q    <= '0;
      created_q  <= '0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (commit_i) begin
        s1_valid_q <= 1'b0;
      end
      if (commit_i) begin
        depth_q   <= depth_d;
        created_q <= created_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_req_q <= req_i;
    end
  end

  assign cnt         = ref_rdata_i;
  assign cnt_dec     = cnt - CountOne;
  assign id_idx      = IDX_W'(s1_req_q.target_id);
  assign not_created = CMP_W'(s1_req_q.target_id) >= CMP_W'(created_q);

  always_comb begin
    status    = ST_OK;
    grant     = '0;
    cnt_out   = '0;
    depth_d   = depth_q;
    created_d = created_q;
    ref_we    = 1'b0;
    ref_waddr = id_idx;
    ref_wdata = cnt;
    stk_we    = 1'b0;
    case (s1_req_q.req_type)
      REQ_ALLOC: begin
        if (depth_q != '0) begin
          depth_d = depth_q - CNT_W'(1);
          grant   = stk_rdata_i;
        end else if (created_q < PoolSize) begin
          grant     = IDX_W'(created_q);
          created_d = created_q + CNT_W'(1);
        end else begin
          status = ST_OUT_OF_BUFS;
        end
        if (status == ST_OK) begin
          ref_we    = 1'b1;
          ref_waddr = grant;
          ref_wdata = CountOne;
          cnt_out   = CountOne;
        end
      end
      default: begin
        if (not_created) begin
          status = (s1_req_q.req_type == REQ_NOP) ? ST_OK : ST_NOT_CREATED;
        end else begin
          case (s1_req_q.req_type)
            REQ_ADD_REF: begin
              if (cnt == '0) begin
                status = ST_ALREADY_REL;
              end else if (cnt == CountMax) begin
                status  = ST_OVERFLOW;
                cnt_out = cnt;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = cnt + CountOne;
                cnt_out   = cnt + CountOne;
              end
            end
            REQ_RELEASE: begin
              if (cnt == '0) begin
                status = ST_ALREADY_REL;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = cnt_dec;
                cnt_out   = cnt_dec;
                // last reference gone: id goes back on the free stack
                if ((cnt_dec == '0) && (depth_q < PoolSize)) begin
                  stk_we  = 1'b1;
                  depth_d = depth_q + CNT_W'(1);
                end
              end
            end
            default: begin
              cnt_out = cnt;
            end
          endcase
        end
      end
    endcase
  end

  // stack top as it stands after the item now committing
  assign depth_eff   = commit_i ? depth_d : depth_q;
  assign stk_raddr_o = IDX_W'(depth_eff - CNT_W'(1));
  assign ref_raddr_o = IDX_W'(req_i.target_id);

  assign ref_we_o    = commit_i && ref_we;
  assign ref_waddr_o = ref_waddr;
  assign ref_wdata_o = ref_wdata;
  assign stk_we_o    = commit_i && stk_we;
  assign stk_waddr_o = IDX_W'(depth_q);
  assign stk_wdata_o = id_idx;

  assign s1_valid_o          = s1_valid_q;
  assign rsp_o.status        = status;
  assign rsp_o.granted_id    = ID_W'(grant);
  assign rsp_o.ref_count     = REF_OUT_W'(cnt_out);
  assign rsp_o.free_count    = TOT_W'(depth_d);
  assign rsp_o.created_count = TOT_W'(created_d);

  `RCBP_ASSERT_ALWAYS(a_depth_bound, !rst_ni || (depth_q <= PoolSize), "free stack deeper than pool")
  `RCBP_ASSERT(a_free_created, depth_q <= created_q, "more free ids than created ids")
  `RCBP_ASSERT(a_commit_valid, commit_i |-> s1_valid_q, "commit without a request held")
  `RCBP_ASSERT(a_hold_state, !commit_i |=> $stable(depth_q) && $stable(created_q), "state moved without commit")

endmodule

### rtl/core/refcounted_buffer_pool.sv
// Reference-counted buffer pool: one request per clock while req_stall_o is low. A
// request is held in an input register while the reference count and free stack
// memories, read at the transfer edge, supply its operands; the decision logic then
// updates the pool and loads the response register. Reads bypass the memories when
// the request ahead writes the same entry, so back-to-back requests on the same id
// run at full rate. No clearing pass follows reset.
`include "refcounted_buffer_pool_defines.svh"

module refcounted_buffer_pool #(
  parameter int unsigned MAX_BUFFERS    = rcbp_pkg::MAX_BUFFERS_DEF,
  parameter int unsigned REF_COUNT_BITS = rcbp_pkg::REF_COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  rcbp_pkg::pool_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output rcbp_pkg::pool_rsp_t rsp_o
);
  import rcbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BUFFERS);

  logic      s1_valid, advance, accept;
  logic      out_valid_q;
  pool_rsp_t rsp_q, core_rsp;

  logic [IDX_W-1:0]          ref_raddr, stk_raddr, ref_waddr, stk_waddr, stk_wdata;
  logic [IDX_W-1:0]          stk_rdata;
  logic [REF_COUNT_BITS-1:0] ref_rdata, ref_wdata;
  logic                      ref_we, stk_we;

  assign advance     = s1_valid && (!out_valid_q || !rsp_stall_i);
  assign req_stall_o = s1_valid && !advance;
  assign accept      = req_valid_i && !req_stall_o;

  rcbp_core #(
    .MAX_BUFFERS    (MAX_BUFFERS),
    .REF_COUNT_BITS (REF_COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .commit_i    (advance),
    .ref_rdata_i (ref_rdata),
    .stk_rdata_i (stk_rdata),
    .s1_valid_o  (s1_valid),
    .rsp_o       (core_rsp),
    .ref_raddr_o (ref_raddr),
    .stk_raddr_o (stk_raddr),
    .ref_we_o    (ref_we),
    .ref_waddr_o (ref_waddr),
    .ref_wdata_o (ref_wdata),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata)
  );

  rcbp_store #(
    .MAX_BUFFERS    (MAX_BUFFERS),
    .REF_COUNT_BITS (REF_COUNT_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .ref_raddr_i (ref_raddr),
    .stk_raddr_i (stk_raddr),
    .ref_we_i    (ref_we),
    .ref_waddr_i (ref_waddr),
    .ref_wdata_i (ref_wdata),
    .stk_we_i    (stk_we),
    .stk_waddr_i (stk_waddr),
    .stk_wdata_i (stk_wdata),
    .ref_rdata_o (ref_rdata),
    .stk_rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= core_rsp;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  `RCBP_ASSERT(a_oob_empty, out_valid_q && (rsp_q.status == ST_OUT_OF_BUFS) |-> (rsp_q.free_count == '0) && (rsp_q.granted_id == '0), "out of buffers with free ids left")
  `RCBP_ASSERT(a_stall_holds, req_stall_o |=> s1_valid, "held request lost while stalled")
  `RCBP_ASSERT(a_grant_ok, out_valid_q && (rsp_q.granted_id != '0) |-> (rsp_q.status == ST_OK) && (rsp_q.ref_count == REF_OUT_W'(1)), "grant without a fresh single reference")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the reference-counted buffer pool.
// Depends on rcbp_pkg and refcounted_buffer_pool; a scoreboard class tracks the
// pool state and checks each response transfer against its prediction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcbp_pkg::*;

  class pool_scoreboard;
    localparam int unsigned POOL_SIZE = MAX_BUFFERS_DEF;
    localparam int unsigned COUNT_TOP = (1 << REF_COUNT_BITS_DEF) - 1;

    logic [ID_W-1:0]      stack_ids [POOL_SIZE];
    int unsigned          stack_depth;
    int unsigned          created_n;
    bit [REF_OUT_W-1:0]   counts [POOL_SIZE];
    pool_rsp_t            expected_q [$];
    int unsigned          mismatches;
    int unsigned          requests;
    int unsigned          responses;
    int unsigned          status_hits [5];

    function new();
      stack_depth = 0;
      created_n   = 0;
      mismatches  = 0;
      requests    = 0;
      responses   = 0;
      foreach (counts[i]) counts[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // Random id that currently holds a reference, or -1 if none does.
    function int pick_live();
      int ids [$];
      foreach (counts[i]) if (counts[i] != 0) ids.push_back(i);
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // Apply one accepted request to the pool and queue its expected response.
    function void note_request(pool_req_t r);
      pool_rsp_t   rsp;
      int unsigned grant;
      int unsigned id;
      bit          granted;
      id = r.target_id;
      rsp = '0;
      rsp.status = ST_OK;
      grant = 0;
      case (r.req_type)
        REQ_ALLOC: begin
          granted = 1'b1;
          if (stack_depth > 0) begin
            stack_depth--;
            grant = stack_ids[stack_depth];
          end else if (created_n < POOL_SIZE) begin
            grant = created_n;
            created_n++;
          end else begin
            granted = 1'b0;
            rsp.status = ST_OUT_OF_BUFS;
          end
          if (granted) begin
            counts[grant] = REF_OUT_W'(1);
            rsp.granted_id = grant[ID_W-1:0];
            rsp.ref_count = REF_OUT_W'(1);
          end
        end
        default: begin
          if (id >= created_n) begin
            if (r.req_type != REQ_NOP) rsp.status = ST_NOT_CREATED;
          end else if (r.req_type == REQ_ADD_REF) begin
            if (counts[id] == 0) begin
              rsp.status = ST_ALREADY_REL;
            end else if (counts[id] == COUNT_TOP) begin
              rsp.status = ST_OVERFLOW;
              rsp.ref_count = counts[id];
            end else begin
              counts[id]++;
              rsp.ref_count = counts[id];
            end
          end else if (r.req_type == REQ_RELEASE) begin
            if (counts[id] == 0) begin
              rsp.status = ST_ALREADY_REL;
            end else begin
              counts[id]--;
              // last reference gone: id goes back on the free stack
              if (counts[id] == 0 && stack_depth < POOL_SIZE) begin
                stack_ids[stack_depth] = id[ID_W-1:0];
                stack_depth++;
              end
              rsp.ref_count = counts[id];
            end
          end else begin
            rsp.ref_count = counts[id];
          end
        end
      endcase
      rsp.free_count    = stack_depth[TOT_W-1:0];
      rsp.created_count = created_n[TOT_W-1:0];
      status_hits[int'(rsp.status)]++;
      requests++;
      expected_q.push_back(rsp);
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(pool_rsp_t got);
      pool_rsp_t want;
      responses++;
      if (expected_q.size() == 0) begin
        report("response transfer with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d exp %0d", got.status, want.status));
      if (got.granted_id !== want.granted_id)
        report($sformatf("granted_id got %0d exp %0d", got.granted_id, want.granted_id));
      if (got.ref_count !== want.ref_count)
        report($sformatf("ref_count got %0d exp %0d", got.ref_count, want.ref_count));
      if (got.free_count !== want.free_count)
        report($sformatf("free_count got %0d exp %0d", got.free_count, want.free_count));
      if (got.created_count !== want.created_count)
        report($sformatf("created_count got %0d exp %0d", got.created_count,
                         want.created_count));
    endtask
  endclass

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned QUIET_FROM     = 1150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_stall_o;
  pool_req_t req_data = '0;
  logic      rsp_valid_o;
  logic      rsp_stall = 1'b0;
  pool_rsp_t rsp_data;

  pool_scoreboard sb;
  bit             quiet = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  refcounted_buffer_pool #(
    .MAX_BUFFERS   (MAX_BUFFERS_DEF),
    .REF_COUNT_BITS(REF_COUNT_BITS_DEF)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall_o),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp_data)
  );

  // Drive one request until its transfer, then maybe leave a gap.
  task automatic issue(input req_e kind, input int unsigned id);
    pool_req_t r;
    r.req_type  = kind;
    r.target_id = id[ID_W-1:0];
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk_i);
    while (req_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Response side: check transfers, stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o === 1'b1 && !rsp_stall) sb.check_response(rsp_data);
      if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && req_stall_o === 1'b0) || (rsp_valid_o === 1'b1 && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          id;
    int unsigned roll;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown ids, first grants, LIFO reuse, double release.
    issue(REQ_RELEASE, 0);
    issue(REQ_ADD_REF, 31);
    issue(REQ_NOP, 31);
    issue(REQ_ALLOC, 31);
    issue(REQ_ALLOC, 0);
    issue(REQ_ADD_REF, 0);
    issue(REQ_NOP, 0);
    issue(REQ_RELEASE, 1);
    issue(REQ_RELEASE, 1);
    issue(REQ_ADD_REF, 1);
    issue(REQ_NOP, 1);
    issue(REQ_ALLOC, 17);
    issue(REQ_RELEASE, 0);
    issue(REQ_RELEASE, 0);
    issue(REQ_RELEASE, 1);
    issue(REQ_ALLOC, 5);
    issue(REQ_ALLOC, 10);
    issue(REQ_ALLOC, 0);
    issue(REQ_ADD_REF, 3);
    issue(REQ_RELEASE, 2);
    drain();

    // Exhaust the pool, saturate one count, then free every id.
    repeat (pool_scoreboard::POOL_SIZE + 2) issue(REQ_ALLOC, $urandom_range(0, 31));
    id = sb.pick_live();
    repeat (pool_scoreboard::COUNT_TOP + 1) issue(REQ_ADD_REF, id);
    for (int i = 0; i < pool_scoreboard::POOL_SIZE; i++) begin
      while (sb.counts[i] != 0) issue(REQ_RELEASE, i);
    end
    issue(REQ_RELEASE, 31);
    issue(REQ_ALLOC, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_FROM) begin
        drain();
        quiet = 1'b1;
      end
      roll = $urandom_range(0, 99);
      id = sb.pick_live();
      if (roll < 15) begin
        issue(req_e'($urandom_range(0, 3)), $urandom_range(0, 31));
      end else if (roll < 45 || id < 0) begin
        issue(REQ_ALLOC, $urandom_range(0, 31));
      end else if (roll < 70) begin
        issue(REQ_ADD_REF, id);
      end else begin
        issue(REQ_RELEASE, id);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Requests %0d, responses checked %0d, mismatches %0d.",
             sb.requests, sb.responses, sb.mismatches);
    $display("Statuses: ok %0d, out of buffers %0d, released %0d, not created %0d, ovf %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
